### design/convex_hull_graham_scan_unit_assert.svh
// assertion macros for the convex hull unit
`ifndef CONVEX_HULL_GRAHAM_SCAN_UNIT_ASSERT_SVH
`define CONVEX_HULL_GRAHAM_SCAN_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define CHG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/chg_pkg.sv
// package of the convex hull unit: constants, command and status types
`default_nettype none
package chg_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 16;
	// sets up to this size are echoed as they came
	localparam int SMALL_SET = 3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_CLR_I,
		OP_SM_RD,
		OP_SM_WR,
		OP_ANC_RD,
		OP_ANC_CMP,
		OP_FI_RD,
		OP_FI_WR,
		OP_SO_INIT,
		OP_SO_RDV,
		OP_SO_LDV,
		OP_SO_RDU,
		OP_SO_DIFF,
		OP_SO_SHIFT,
		OP_SO_PUT,
		OP_DD_RD,
		OP_DD_DIFF,
		OP_DD_ACT,
		OP_SC_INIT,
		OP_SC_RD,
		OP_SC_LDP,
		OP_SC_DIFF,
		OP_SC_POP,
		OP_SC_LDS,
		OP_SC_PUSH,
		OP_EM_RD,
		OP_EM_WR,
		OP_DONE
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE,
		S_DECIDE,
		S_SM_RD,
		S_SM_WR,
		S_ANC_RD,
		S_ANC_CMP,
		S_FI_CLR,
		S_FI_RD,
		S_FI_WR,
		S_SO_INIT,
		S_SO_CHK,
		S_SO_RDV,
		S_SO_LDV,
		S_SO_J,
		S_SO_RDU,
		S_SO_DIFF,
		S_SO_MUL,
		S_SO_ACT,
		S_SO_PUT,
		S_DD_CLR,
		S_DD_CHK,
		S_DD_RD,
		S_DD_DIFF,
		S_DD_MUL,
		S_DD_ACT,
		S_SC_INIT,
		S_SC_CHK,
		S_SC_RD,
		S_SC_LDP,
		S_SC_TEST,
		S_SC_DIFF,
		S_SC_MUL,
		S_SC_ACT,
		S_SC_LDS,
		S_SC_PUSH,
		S_EM_CLR,
		S_EM_RD,
		S_EM_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic in_ready;
	} ctl_t;

	typedef struct packed {
		logic in_acc;
		logic in_final;
		logic n_small;
		logic sm_last;
		logic em_last;
		logic i_last_n;
		logic i_ge_m;
		logic i_eq_kept;
		logic j_zero;
		logic depth_gt2;
		logic gt;
		logic zero;
		logic dgt;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

### design/chg_if.sv
// stream interfaces for points in and hull vertices out
`default_nettype none
interface chg_pt_if #(
	parameter int COORD_BITS = chg_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic                         final_point;

	modport source (output valid, px, py, final_point, input ready);
	modport sink (input valid, px, py, final_point, output ready);
endinterface

interface chg_hull_if #(
	parameter int COORD_BITS = chg_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] hx;
	logic signed [COORD_BITS-1:0] hy;
	logic                         final_vertex;
	logic                         points_dropped;

	modport source (output valid, hx, hy, final_vertex, points_dropped, input ready);
	modport sink (input valid, hx, hy, final_vertex, points_dropped, output ready);
endinterface
`default_nettype wire

### design/chg_datapath.sv
// datapath: point, order and stack memories, orientation unit, output register
`default_nettype none
module chg_datapath #(
	parameter int MAX_POINTS = chg_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = chg_pkg::COORD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	chg_pt_if.sink             pts,
	chg_hull_if.source         hull,
	input  chg_pkg::ctl_t      ctl,
	output chg_pkg::stat_t     stat
);
	localparam int W     = COORD_BITS;
	localparam int PW    = 2 * COORD_BITS;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	// memories, one write and one registered read each
	logic [PW-1:0]    pts_mem [MAX_POINTS];
	logic [PW-1:0]    wl_mem  [MAX_POINTS];
	logic [PW-1:0]    hs_mem  [MAX_POINTS];
	logic [PW-1:0]    pts_rd_q, wl_rd_q, hs_rd_q;
	logic [IDX_W-1:0] pts_ra, wl_ra, hs_ra, wl_wa, hs_wa;
	logic             pts_we, wl_we, hs_we;
	logic [PW-1:0]    wl_wd, hs_wd;

	logic [CNT_W-1:0] cnt_q, i_q, j_q, m_q, kept_q, depth_q, k_q;
	logic             ovf_q;
	logic [PW-1:0]    anc_q, v_q, b_q, lk_q, top_q, sec_q, p_q;

	logic             ov_q, ofin_q, odrop_q;
	logic [PW-1:0]    oword_q;

	logic             acc;
	logic [CNT_W-1:0] jm1, dm3, cm1, dm1;
	logic [PW-1:0]    o_w, a_w, b_w;
	logic             anc_less, out_load;

	logic signed [W:0]       dax_c, day_c, dbx_c, dby_c;
	logic signed [W:0]       dax_s1, day_s1, dbx_s1, dby_s1;
	logic signed [2*W+1:0]   p_axby_s2, p_aybx_s2, p_axax_s2, p_ayay_s2, p_bxbx_s2, p_byby_s2;
	logic signed [2*W+2:0]   orient_c;
	logic [2*W+2:0]          dist_a_c, dist_b_c;

	assign acc       = pts.valid && ctl.in_ready;
	assign pts.ready = ctl.in_ready;

	assign jm1 = j_q - CNT_W'(1);
	assign dm3 = depth_q - CNT_W'(3);
	assign cm1 = cnt_q - CNT_W'(1);
	assign dm1 = depth_q - CNT_W'(1);

	assign anc_less = ($signed(pts_rd_q[W-1:0]) < $signed(anc_q[W-1:0])) ||
		(($signed(pts_rd_q[W-1:0]) == $signed(anc_q[W-1:0])) &&
		 ($signed(pts_rd_q[PW-1:W]) < $signed(anc_q[PW-1:W])));

	// memory address and write control
	always_comb begin
		pts_ra = k_q[IDX_W-1:0];
		wl_ra  = i_q[IDX_W-1:0];
		hs_ra  = k_q[IDX_W-1:0];
		pts_we = acc && (cnt_q < CNT_W'(MAX_POINTS));
		wl_we  = 1'b0;
		wl_wa  = m_q[IDX_W-1:0];
		wl_wd  = pts_rd_q;
		hs_we  = 1'b0;
		hs_wa  = depth_q[IDX_W-1:0];
		hs_wd  = p_q;
		case (ctl.op)
			chg_pkg::OP_ANC_RD,
			chg_pkg::OP_FI_RD: pts_ra = i_q[IDX_W-1:0];
			chg_pkg::OP_FI_WR: begin
				wl_we = (pts_rd_q != anc_q);
			end
			chg_pkg::OP_SO_RDU: wl_ra = jm1[IDX_W-1:0];
			chg_pkg::OP_SO_SHIFT: begin
				wl_we = 1'b1;
				wl_wa = j_q[IDX_W-1:0];
				wl_wd = b_q;
			end
			chg_pkg::OP_SO_PUT: begin
				wl_we = 1'b1;
				wl_wa = j_q[IDX_W-1:0];
				wl_wd = v_q;
			end
			chg_pkg::OP_DD_ACT: begin
				wl_we = (kept_q == '0) || !stat.zero;
				wl_wa = kept_q[IDX_W-1:0];
				wl_wd = b_q;
			end
			chg_pkg::OP_SC_INIT: begin
				hs_we = 1'b1;
				hs_wa = '0;
				hs_wd = anc_q;
			end
			chg_pkg::OP_SC_POP: hs_ra = dm3[IDX_W-1:0];
			chg_pkg::OP_SC_PUSH: hs_we = (depth_q < CNT_W'(MAX_POINTS));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		pts_rd_q <= pts_mem[pts_ra];
		if (pts_we)
			pts_mem[cnt_q[IDX_W-1:0]] <= {pts.px, pts.py};
	end

	always_ff @(posedge clk) begin
		wl_rd_q <= wl_mem[wl_ra];
		if (wl_we)
			wl_mem[wl_wa] <= wl_wd;
	end

	always_ff @(posedge clk) begin
		hs_rd_q <= hs_mem[hs_ra];
		if (hs_we)
			hs_mem[hs_wa] <= hs_wd;
	end

	// orientation unit: differences, products, then compare
	always_comb begin
		o_w = top_q;
		a_w = sec_q;
		b_w = p_q;
		case (ctl.op)
			chg_pkg::OP_SO_DIFF: begin
				o_w = anc_q;
				a_w = v_q;
				b_w = wl_rd_q;
			end
			chg_pkg::OP_DD_DIFF: begin
				o_w = anc_q;
				a_w = lk_q;
				b_w = wl_rd_q;
			end
			default: ;
		endcase
	end

	assign dax_c = $signed({a_w[PW-1], a_w[PW-1:W]}) - $signed({o_w[PW-1], o_w[PW-1:W]});
	assign day_c = $signed({a_w[W-1], a_w[W-1:0]}) - $signed({o_w[W-1], o_w[W-1:0]});
	assign dbx_c = $signed({b_w[PW-1], b_w[PW-1:W]}) - $signed({o_w[PW-1], o_w[PW-1:W]});
	assign dby_c = $signed({b_w[W-1], b_w[W-1:0]}) - $signed({o_w[W-1], o_w[W-1:0]});

	always_ff @(posedge clk) begin
		dax_s1    <= dax_c;
		day_s1    <= day_c;
		dbx_s1    <= dbx_c;
		dby_s1    <= dby_c;
		p_axby_s2 <= dax_s1 * dby_s1;
		p_aybx_s2 <= day_s1 * dbx_s1;
		p_axax_s2 <= dax_s1 * dax_s1;
		p_ayay_s2 <= day_s1 * day_s1;
		p_bxbx_s2 <= dbx_s1 * dbx_s1;
		p_byby_s2 <= dby_s1 * dby_s1;
	end

	assign orient_c = $signed({p_axby_s2[2*W+1], p_axby_s2}) -
		$signed({p_aybx_s2[2*W+1], p_aybx_s2});
	// squares are never negative
	assign dist_a_c = {1'b0, p_axax_s2} + {1'b0, p_ayay_s2};
	assign dist_b_c = {1'b0, p_bxbx_s2} + {1'b0, p_byby_s2};

	// counters and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			m_q     <= '0;
			kept_q  <= '0;
			depth_q <= '0;
			k_q     <= '0;
		end else begin
			if (acc) begin
				if (cnt_q < CNT_W'(MAX_POINTS))
					cnt_q <= cnt_q + CNT_W'(1);
				else
					ovf_q <= 1'b1;
			end
			case (ctl.op)
				chg_pkg::OP_CLR: begin
					i_q    <= '0;
					k_q    <= '0;
					m_q    <= '0;
					kept_q <= '0;
				end
				chg_pkg::OP_CLR_I: begin
					i_q <= '0;
					k_q <= '0;
				end
				chg_pkg::OP_SM_WR,
				chg_pkg::OP_EM_WR: k_q <= k_q + CNT_W'(1);
				chg_pkg::OP_ANC_CMP: i_q <= i_q + CNT_W'(1);
				chg_pkg::OP_FI_WR: begin
					i_q <= i_q + CNT_W'(1);
					if (wl_we)
						m_q <= m_q + CNT_W'(1);
				end
				chg_pkg::OP_SO_INIT: i_q <= CNT_W'(1);
				chg_pkg::OP_SO_LDV: j_q <= i_q;
				chg_pkg::OP_SO_SHIFT: j_q <= jm1;
				chg_pkg::OP_SO_PUT: i_q <= i_q + CNT_W'(1);
				chg_pkg::OP_DD_ACT: begin
					i_q <= i_q + CNT_W'(1);
					if (wl_we)
						kept_q <= kept_q + CNT_W'(1);
				end
				chg_pkg::OP_SC_INIT: begin
					depth_q <= CNT_W'(1);
					i_q     <= '0;
				end
				chg_pkg::OP_SC_POP: depth_q <= dm1;
				chg_pkg::OP_SC_PUSH: begin
					i_q <= i_q + CNT_W'(1);
					if (hs_we)
						depth_q <= depth_q + CNT_W'(1);
				end
				chg_pkg::OP_DONE: begin
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					depth_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// point registers of the sort and scan
	always_ff @(posedge clk) begin
		case (ctl.op)
			chg_pkg::OP_ANC_CMP: begin
				if ((i_q == '0) || anc_less)
					anc_q <= pts_rd_q;
			end
			chg_pkg::OP_SO_LDV: v_q <= wl_rd_q;
			chg_pkg::OP_SO_DIFF,
			chg_pkg::OP_DD_DIFF: b_q <= wl_rd_q;
			chg_pkg::OP_DD_ACT: begin
				if (wl_we)
					lk_q <= b_q;
			end
			chg_pkg::OP_SC_INIT: top_q <= anc_q;
			chg_pkg::OP_SC_LDP: p_q <= wl_rd_q;
			chg_pkg::OP_SC_POP: top_q <= sec_q;
			chg_pkg::OP_SC_LDS: sec_q <= hs_rd_q;
			chg_pkg::OP_SC_PUSH: begin
				if (hs_we) begin
					sec_q <= top_q;
					top_q <= p_q;
				end
			end
			default: ;
		endcase
	end

	// output register
	assign out_load = (ctl.op == chg_pkg::OP_SM_WR) || (ctl.op == chg_pkg::OP_EM_WR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (hull.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == chg_pkg::OP_SM_WR) begin
			oword_q <= pts_rd_q;
			ofin_q  <= (k_q == cm1);
			odrop_q <= ovf_q;
		end else if (ctl.op == chg_pkg::OP_EM_WR) begin
			oword_q <= hs_rd_q;
			ofin_q  <= (k_q == dm1);
			odrop_q <= ovf_q;
		end
	end

	assign hull.valid          = ov_q;
	assign hull.hx             = oword_q[PW-1:W];
	assign hull.hy             = oword_q[W-1:0];
	assign hull.final_vertex   = ofin_q;
	assign hull.points_dropped = odrop_q;

	// status to the controller
	always_comb begin
		stat.in_acc    = acc;
		stat.in_final  = pts.final_point;
		stat.n_small   = (cnt_q <= CNT_W'(chg_pkg::SMALL_SET));
		stat.sm_last   = (k_q == cm1);
		stat.em_last   = (k_q == dm1);
		stat.i_last_n  = (i_q == cm1);
		stat.i_ge_m    = (i_q >= m_q);
		stat.i_eq_kept = (i_q == kept_q);
		stat.j_zero    = (j_q == '0);
		stat.depth_gt2 = (depth_q > CNT_W'(2));
		stat.gt        = (orient_c > 0);
		stat.zero      = (orient_c == '0);
		stat.dgt       = (dist_a_c > dist_b_c);
		stat.out_free  = !ov_q;
	end

endmodule
`default_nettype wire

### design/chg_ctrl.sv
// controller: sequencer of load, anchor search, sort, filter, scan and emit
`default_nettype none
module chg_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  chg_pkg::stat_t stat,
	output chg_pkg::ctl_t  ctl
);
	chg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= chg_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		ctl.op       = chg_pkg::OP_NONE;
		ctl.in_ready = 1'b0;
		case (state_q)
			chg_pkg::S_IDLE: begin
				ctl.in_ready = 1'b1;
				if (stat.in_acc && stat.in_final)
					state_d = chg_pkg::S_DECIDE;
			end
			chg_pkg::S_DECIDE: begin
				ctl.op  = chg_pkg::OP_CLR;
				state_d = stat.n_small ? chg_pkg::S_SM_RD : chg_pkg::S_ANC_RD;
			end
			chg_pkg::S_SM_RD: begin
				if (stat.out_free) begin
					ctl.op  = chg_pkg::OP_SM_RD;
					state_d = chg_pkg::S_SM_WR;
				end
			end
			chg_pkg::S_SM_WR: begin
				ctl.op  = chg_pkg::OP_SM_WR;
				state_d = stat.sm_last ? chg_pkg::S_DONE : chg_pkg::S_SM_RD;
			end
			chg_pkg::S_ANC_RD: begin
				ctl.op  = chg_pkg::OP_ANC_RD;
				state_d = chg_pkg::S_ANC_CMP;
			end
			chg_pkg::S_ANC_CMP: begin
				ctl.op  = chg_pkg::OP_ANC_CMP;
				state_d = stat.i_last_n ? chg_pkg::S_FI_CLR : chg_pkg::S_ANC_RD;
			end
			chg_pkg::S_FI_CLR: begin
				ctl.op  = chg_pkg::OP_CLR_I;
				state_d = chg_pkg::S_FI_RD;
			end
			chg_pkg::S_FI_RD: begin
				ctl.op  = chg_pkg::OP_FI_RD;
				state_d = chg_pkg::S_FI_WR;
			end
			chg_pkg::S_FI_WR: begin
				// copies of the anchor are left out here
				ctl.op  = chg_pkg::OP_FI_WR;
				state_d = stat.i_last_n ? chg_pkg::S_SO_INIT : chg_pkg::S_FI_RD;
			end
			chg_pkg::S_SO_INIT: begin
				ctl.op  = chg_pkg::OP_SO_INIT;
				state_d = chg_pkg::S_SO_CHK;
			end
			chg_pkg::S_SO_CHK: begin
				state_d = stat.i_ge_m ? chg_pkg::S_DD_CLR : chg_pkg::S_SO_RDV;
			end
			chg_pkg::S_SO_RDV: begin
				ctl.op  = chg_pkg::OP_SO_RDV;
				state_d = chg_pkg::S_SO_LDV;
			end
			chg_pkg::S_SO_LDV: begin
				ctl.op  = chg_pkg::OP_SO_LDV;
				state_d = chg_pkg::S_SO_J;
			end
			chg_pkg::S_SO_J: begin
				state_d = stat.j_zero ? chg_pkg::S_SO_PUT : chg_pkg::S_SO_RDU;
			end
			chg_pkg::S_SO_RDU: begin
				ctl.op  = chg_pkg::OP_SO_RDU;
				state_d = chg_pkg::S_SO_DIFF;
			end
			chg_pkg::S_SO_DIFF: begin
				ctl.op  = chg_pkg::OP_SO_DIFF;
				state_d = chg_pkg::S_SO_MUL;
			end
			chg_pkg::S_SO_MUL: begin
				state_d = chg_pkg::S_SO_ACT;
			end
			chg_pkg::S_SO_ACT: begin
				// counter-clockwise first, then farther first on one ray
				if (stat.gt || (stat.zero && stat.dgt)) begin
					ctl.op  = chg_pkg::OP_SO_SHIFT;
					state_d = chg_pkg::S_SO_J;
				end else begin
					state_d = chg_pkg::S_SO_PUT;
				end
			end
			chg_pkg::S_SO_PUT: begin
				ctl.op  = chg_pkg::OP_SO_PUT;
				state_d = chg_pkg::S_SO_CHK;
			end
			chg_pkg::S_DD_CLR: begin
				ctl.op  = chg_pkg::OP_CLR_I;
				state_d = chg_pkg::S_DD_CHK;
			end
			chg_pkg::S_DD_CHK: begin
				state_d = stat.i_ge_m ? chg_pkg::S_SC_INIT : chg_pkg::S_DD_RD;
			end
			chg_pkg::S_DD_RD: begin
				ctl.op  = chg_pkg::OP_DD_RD;
				state_d = chg_pkg::S_DD_DIFF;
			end
			chg_pkg::S_DD_DIFF: begin
				ctl.op  = chg_pkg::OP_DD_DIFF;
				state_d = chg_pkg::S_DD_MUL;
			end
			chg_pkg::S_DD_MUL: begin
				state_d = chg_pkg::S_DD_ACT;
			end
			chg_pkg::S_DD_ACT: begin
				ctl.op  = chg_pkg::OP_DD_ACT;
				state_d = chg_pkg::S_DD_CHK;
			end
			chg_pkg::S_SC_INIT: begin
				ctl.op  = chg_pkg::OP_SC_INIT;
				state_d = chg_pkg::S_SC_CHK;
			end
			chg_pkg::S_SC_CHK: begin
				state_d = stat.i_eq_kept ? chg_pkg::S_EM_CLR : chg_pkg::S_SC_RD;
			end
			chg_pkg::S_SC_RD: begin
				ctl.op  = chg_pkg::OP_SC_RD;
				state_d = chg_pkg::S_SC_LDP;
			end
			chg_pkg::S_SC_LDP: begin
				ctl.op  = chg_pkg::OP_SC_LDP;
				state_d = chg_pkg::S_SC_TEST;
			end
			chg_pkg::S_SC_TEST: begin
				state_d = stat.depth_gt2 ? chg_pkg::S_SC_DIFF : chg_pkg::S_SC_PUSH;
			end
			chg_pkg::S_SC_DIFF: begin
				ctl.op  = chg_pkg::OP_SC_DIFF;
				state_d = chg_pkg::S_SC_MUL;
			end
			chg_pkg::S_SC_MUL: begin
				state_d = chg_pkg::S_SC_ACT;
			end
			chg_pkg::S_SC_ACT: begin
				// strict right turn pops the top vertex
				if (stat.gt) begin
					ctl.op  = chg_pkg::OP_SC_POP;
					state_d = chg_pkg::S_SC_LDS;
				end else begin
					state_d = chg_pkg::S_SC_PUSH;
				end
			end
			chg_pkg::S_SC_LDS: begin
				ctl.op  = chg_pkg::OP_SC_LDS;
				state_d = chg_pkg::S_SC_TEST;
			end
			chg_pkg::S_SC_PUSH: begin
				ctl.op  = chg_pkg::OP_SC_PUSH;
				state_d = chg_pkg::S_SC_CHK;
			end
			chg_pkg::S_EM_CLR: begin
				ctl.op  = chg_pkg::OP_CLR_I;
				state_d = chg_pkg::S_EM_RD;
			end
			chg_pkg::S_EM_RD: begin
				if (stat.out_free) begin
					ctl.op  = chg_pkg::OP_EM_RD;
					state_d = chg_pkg::S_EM_WR;
				end
			end
			chg_pkg::S_EM_WR: begin
				ctl.op  = chg_pkg::OP_EM_WR;
				state_d = stat.em_last ? chg_pkg::S_DONE : chg_pkg::S_EM_RD;
			end
			chg_pkg::S_DONE: begin
				ctl.op  = chg_pkg::OP_DONE;
				state_d = chg_pkg::S_IDLE;
			end
			default: begin
				state_d = chg_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/convex_hull_graham_scan_unit.sv
// top level of the convex hull unit: controller, datapath and checks
// Points are taken one word per cycle while the unit is idle; the word
// with final_point set closes the set and starts the hull run, during which
// no point is taken. A run searches the stored points for the anchor,
// drops copies of the anchor, insertion-sorts the rest (slowest when the
// order comes reversed), thins each ray with the ray filter, runs the
// stack scan with its pops and sends the hull vertices out while the sink
// keeps up; all of it is paced by the single orientation unit (differences,
// products, compare) and the one read port of each memory.
// Sets of three or fewer points come back in arrival order. Points past
// MAX_POINTS are dropped and every vertex of that set carries
// points_dropped.
`default_nettype none
`include "convex_hull_graham_scan_unit_assert.svh"
module convex_hull_graham_scan_unit #(
	parameter int MAX_POINTS = chg_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = chg_pkg::COORD_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	chg_pt_if.sink     pts,
	chg_hull_if.source hull
);
	chg_pkg::ctl_t  ctl;
	chg_pkg::stat_t stat;

	chg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	chg_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.pts    (pts),
		.hull   (hull),
		.ctl    (ctl),
		.stat   (stat)
	);

	// closing word starts a run, so intake stops
	`CHG_ASSERT_NXT(a_busy_after_final, pts.valid && pts.ready && pts.final_point, !pts.ready, "intake open after closing word")
	// a vertex is only loaded into a free output register
	`CHG_ASSERT_IMP(a_no_overwrite, ctl.op == chg_pkg::OP_SM_WR || ctl.op == chg_pkg::OP_EM_WR, !hull.valid, "output word overwritten")
	// nothing follows the last vertex straight away
	`CHG_ASSERT_NXT(a_gap_after_last, hull.valid && hull.ready && hull.final_vertex, !hull.valid, "word right after last vertex")

endmodule
`default_nettype wire

### tb/tb.sv
// testbench of the convex hull unit: directed and random point sets checked against a hull predictor
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPTS = chg_pkg::MAX_POINTS_DEF;
	localparam int CB = chg_pkg::COORD_BITS_DEF;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 fin;
	} point_word_t;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 fin;
		logic                 dropped;
	} vertex_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	chg_pt_if #(.COORD_BITS(CB)) pts ();
	chg_hull_if #(.COORD_BITS(CB)) hull ();

	convex_hull_graham_scan_unit #(.MAX_POINTS(NPTS), .COORD_BITS(CB)) u_dut (
		.clk(clk), .arst_n(arst_n), .pts(pts), .hull(hull)
	);

	point_word_t pending_points[$];
	vertex_t     hull_expected[$];
	int          errors = 0;
	bit          stim_done = 0;
	bit          calm = 0;
	bit          hold_long = 0;

	// predictor state
	logic signed [CB-1:0] set_x[NPTS];
	logic signed [CB-1:0] set_y[NPTS];
	int                   set_count = 0;
	bit                   set_overflow = 0;

	function automatic longint cross3(int o, int a, int b);
		longint ax, ay, bx, by;
		ax = longint'(set_x[a]) - set_x[o];
		ay = longint'(set_y[a]) - set_y[o];
		bx = longint'(set_x[b]) - set_x[o];
		by = longint'(set_y[b]) - set_y[o];
		return ax * by - ay * bx;
	endfunction

	function automatic longint dsq(int o, int a);
		longint dx, dy;
		dx = longint'(set_x[a]) - set_x[o];
		dy = longint'(set_y[a]) - set_y[o];
		return dx * dx + dy * dy;
	endfunction

	function automatic bit ahead_of(int anc, int a, int b);
		longint c;
		c = cross3(anc, a, b);
		if (c != 0) return c > 0;
		return dsq(anc, a) > dsq(anc, b);
	endfunction

	function automatic void push_vertex(int idx, bit last);
		vertex_t v;
		v.x = set_x[idx];
		v.y = set_y[idx];
		v.fin = last;
		v.dropped = set_overflow;
		hull_expected = {hull_expected, v};
	endfunction

	// take one point into the set; a final point yields the hull, or the set as it came when small
	function automatic void predict_hull(point_word_t p);
		int anc, m, kept, depth, v, j;
		int order[NPTS];
		int stk[NPTS];
		if (set_count < NPTS) begin
			set_x[set_count] = p.x;
			set_y[set_count] = p.y;
			set_count++;
		end else begin
			set_overflow = 1;
		end
		if (!p.fin) return;
		if (set_count <= chg_pkg::SMALL_SET) begin
			for (int i = 0; i < set_count; i++) push_vertex(i, i + 1 == set_count);
		end else begin
			anc = 0;
			for (int i = 1; i < set_count; i++)
				if (set_y[i] < set_y[anc] || (set_y[i] == set_y[anc] && set_x[i] < set_x[anc]))
					anc = i;
			m = 0;
			for (int i = 0; i < set_count; i++) begin
				if (i == anc) continue;
				if (set_x[i] == set_x[anc] && set_y[i] == set_y[anc]) continue;
				order[m++] = i;
			end
			for (int i = 1; i < m; i++) begin
				v = order[i];
				j = i;
				while (j > 0 && ahead_of(anc, v, order[j-1])) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = v;
			end
			kept = 0;
			for (int i = 0; i < m; i++)
				if (kept == 0 || cross3(anc, order[kept-1], order[i]) != 0)
					order[kept++] = order[i];
			depth = 0;
			stk[depth++] = anc;
			for (int i = 0; i < kept; i++) begin
				while (depth > 2 && cross3(stk[depth-1], stk[depth-2], order[i]) > 0)
					depth--;
				if (depth < NPTS) stk[depth++] = order[i];
			end
			for (int i = 0; i < depth; i++) push_vertex(stk[i], i + 1 == depth);
		end
		set_count = 0;
		set_overflow = 0;
	endfunction

	function automatic logic signed [CB-1:0] rand_coord(int mode);
		case (mode)
			0: return CB'($urandom);
			1: return CB'(int'($urandom_range(0, 20)) - 10);
			default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
		endcase
	endfunction

	function automatic void add_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y, bit f);
		point_word_t p;
		p.x = x;
		p.y = y;
		p.fin = f;
		pending_points = {pending_points, p};
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts.valid <= 1'b0;
			pts.px <= '0;
			pts.py <= '0;
			pts.final_point <= 1'b0;
		end else begin
			if (pts.valid && pts.ready) begin
				predict_hull('{pts.px, pts.py, pts.final_point});
				void'(pending_points.pop_front());
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				pts.valid <= 1'b0;
			end else if (!(pts.valid && !pts.ready) && !calm && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 6);
				pts.valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				pts.valid <= 1'b1;
				pts.px <= pending_points[0].x;
				pts.py <= pending_points[0].y;
				pts.final_point <= pending_points[0].fin;
			end else begin
				pts.valid <= 1'b0;
			end
		end
	end

	// sink stalls and monitor
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		vertex_t e;
		if (!arst_n) begin
			hull.ready <= 1'b0;
		end else begin
			if (hull.valid && hull.ready) begin
				if (hull_expected.size() == 0) begin
					errors++;
					$display("%0t unexpected vertex %0d,%0d", $time, hull.hx, hull.hy);
				end else begin
					e = hull_expected.pop_front();
					if (hull.hx !== e.x || hull.hy !== e.y || hull.final_vertex !== e.fin ||
						hull.points_dropped !== e.dropped) begin
						errors++;
						$display("%0t vertex mismatch: expected %0d,%0d fin %0b drop %0b, got %0d,%0d fin %0b drop %0b",
							$time, e.x, e.y, e.fin, e.dropped,
							hull.hx, hull.hy, hull.final_vertex, hull.points_dropped);
					end
				end
			end
			if (hold_long) begin
				hull.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				hull.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 6);
				hull.ready <= 1'b0;
			end else begin
				hull.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off, counted here, started once a word is waiting
	initial begin
		wait (arst_n);
		repeat (20) @(posedge clk);
		@(posedge clk iff hull.valid);
		hold_long <= 1'b1;
		repeat (1500) @(posedge clk);
		hold_long <= 1'b0;
	end

	initial begin
		int n, mode;
		// directed: small sets, extremes, copies of the anchor, collinear runs
		add_point(16'sh8000, 16'sh8000, 1'b1);
		add_point(16'sh7fff, 16'sh8000, 1'b0); add_point(16'sh0000, 16'sh7fff, 1'b1);
		add_point(16'sh8000, 16'sh8000, 1'b0); add_point(16'sh7fff, 16'sh8000, 1'b0);
		add_point(16'sh7fff, 16'sh7fff, 1'b0); add_point(16'sh8000, 16'sh7fff, 1'b1);
		add_point(16'sd0, 16'sd0, 1'b0); add_point(16'sd0, 16'sd0, 1'b0);
		add_point(16'sd1, 16'sd1, 1'b0);
		add_point(16'sd2, 16'sd2, 1'b0); add_point(16'sd3, 16'sd3, 1'b1);
		add_point(16'sd0, 16'sd0, 1'b0); add_point(16'sd4, 16'sd0, 1'b0);
		add_point(16'sd2, 16'sd0, 1'b0);
		add_point(16'sd4, 16'sd4, 1'b0); add_point(16'sd0, 16'sd4, 1'b0);
		add_point(16'sd2, 16'sd4, 1'b0); add_point(16'sd1, 16'sd1, 1'b1);
		// overflow set: capacity plus a few, final one dropped
		for (int i = 0; i < NPTS + 3; i++)
			add_point(rand_coord(i % 3), rand_coord(0), i == NPTS + 2);
		// random sets, mostly of 4 to 12 points
		while (pending_points.size() < 110) begin
			n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(4, 12);
			mode = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) add_point(rand_coord(mode), rand_coord(mode), i == n - 1);
		end
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_points.size() < 30);
		calm = 1;
		wait (pending_points.size() == 0);
		wait (hull_expected.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("** convex_hull_graham_scan_unit: PASSED **");
		else
			$display("** convex_hull_graham_scan_unit: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** convex_hull_graham_scan_unit: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
